FILE: rtl/fds_pkg.sv
// Shared types and constants of the Forth data stack unit.
// Depends on nothing; every other file of the block but fds_ram imports it.
`default_nettype none

package fds_pkg;

    // Stack size and the widths that follow from it.
    localparam int STACK_DEPTH = 256;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DATA_W      = 32;

    // Operation codes of a request.
    typedef enum logic [3:0] {
        OP_PUSH  = 4'd0,
        OP_DROP  = 4'd1,
        OP_DUP   = 4'd2,
        OP_SWAP  = 4'd3,
        OP_ROT   = 4'd4,
        OP_OVER  = 4'd5,
        OP_PRINT = 4'd6,
        OP_EMIT  = 4'd7,
        OP_CR    = 4'd8
    } op_t;

    // Completion status of an operation.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2
    } status_t;

    // Kind of printed output.
    typedef enum logic [1:0] {
        KIND_NUM  = 2'd0,
        KIND_CHAR = 2'd1,
        KIND_NL   = 2'd2
    } kind_t;

    // One decoded request.
    typedef struct packed {
        op_t                      op;
        logic signed [DATA_W-1:0] literal;
    } req_t;

    // One result item.
    typedef struct packed {
        status_t                  status;
        logic                     has_output;
        kind_t                    output_kind;
        logic signed [DATA_W-1:0] output_value;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/fds_if.sv
// Valid/ready channel interfaces for requests and results of the stack unit.
// Depends on fds_pkg for the data width.
`default_nettype none

interface fds_req_if
    import fds_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [3:0]               req_type;
    logic signed [DATA_W-1:0] literal;

    modport source (output valid, output req_type, output literal, input ready);
    modport sink   (input valid, input req_type, input literal, output ready);
endinterface

interface fds_rsp_if
    import fds_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic                     has_output;
    logic [1:0]               output_kind;
    logic signed [DATA_W-1:0] output_value;

    modport source (output valid, output status, output has_output, output output_kind,
                    output output_value, input ready);
    modport sink   (input valid, input status, input has_output, input output_kind,
                    input output_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/fds_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module fds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port; a read of the address being
    // written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: rtl/fds_stack.sv
// Stack core: top three entries cached in registers, the rest in a RAM
// with a prefetched fourth entry. Depends on fds_pkg and fds_ram.
`default_nettype none

module fds_stack
    import fds_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    accept,
    input  wire req_t    req,
    output result_t      result
);

    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [DATA_W-1:0]  top0_reg, top0_next;
    logic [DATA_W-1:0]  top1_reg, top1_next;
    logic [DATA_W-1:0]  top2_reg, top2_next;
    logic               byp_valid_reg;
    logic [DATA_W-1:0]  byp_data_reg;
    logic [DATA_W-1:0]  rd_data;
    logic [DATA_W-1:0]  top3;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [1:0]         need;
    logic               grow;
    logic               known;
    logic               under;
    logic               over;
    logic               ok;
    logic [DEPTH_W-1:0] depth_m3;
    logic [DEPTH_W-1:0] depth_m4;

    // Entries below the cached three live in the RAM.
    fds_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (top2_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The fourth entry comes from the bypass when it was spilled last cycle.
    assign top3 = byp_valid_reg ? byp_data_reg : rd_data;

    // Depth requirements of each operation.
    always_comb
    begin
        need  = 2'd0;
        grow  = 1'b0;
        known = 1'b1;
        case (req.op)
            OP_PUSH:  begin need = 2'd0; grow = 1'b1; end
            OP_DROP:  begin need = 2'd1; grow = 1'b0; end
            OP_DUP:   begin need = 2'd1; grow = 1'b1; end
            OP_SWAP:  begin need = 2'd2; grow = 1'b0; end
            OP_ROT:   begin need = 2'd3; grow = 1'b0; end
            OP_OVER:  begin need = 2'd2; grow = 1'b1; end
            OP_PRINT: begin need = 2'd1; grow = 1'b0; end
            OP_EMIT:  begin need = 2'd1; grow = 1'b0; end
            OP_CR:    begin need = 2'd0; grow = 1'b0; end
            default:  known = 1'b0;
        endcase
    end

    assign under = known && (depth_reg < DEPTH_W'(need));
    assign over  = known && !under && grow && (depth_reg >= DEPTH_W'(STACK_DEPTH));
    assign ok    = accept && known && !under && !over;

    // The spilled entry goes to index depth-3; the next prefetch reads
    // index depth-4 of the updated depth.
    assign depth_m3 = depth_reg - DEPTH_W'(3);
    assign depth_m4 = depth_next - DEPTH_W'(4);
    assign wr_addr  = depth_m3[ADDR_W-1:0];
    assign rd_addr  = depth_m4[ADDR_W-1:0];

    // Next stack contents.
    always_comb
    begin
        depth_next = depth_reg;
        top0_next  = top0_reg;
        top1_next  = top1_reg;
        top2_next  = top2_reg;
        wr_en      = 1'b0;
        if (ok)
        begin
            case (req.op)
                OP_PUSH:
                begin
                    top0_next  = req.literal;
                    top1_next  = top0_reg;
                    top2_next  = top1_reg;
                    wr_en      = depth_reg >= DEPTH_W'(3);
                    depth_next = depth_reg + DEPTH_W'(1);
                end
                OP_DUP:
                begin
                    top1_next  = top0_reg;
                    top2_next  = top1_reg;
                    wr_en      = depth_reg >= DEPTH_W'(3);
                    depth_next = depth_reg + DEPTH_W'(1);
                end
                OP_OVER:
                begin
                    top0_next  = top1_reg;
                    top1_next  = top0_reg;
                    top2_next  = top1_reg;
                    wr_en      = depth_reg >= DEPTH_W'(3);
                    depth_next = depth_reg + DEPTH_W'(1);
                end
                OP_DROP, OP_PRINT, OP_EMIT:
                begin
                    top0_next  = top1_reg;
                    top1_next  = top2_reg;
                    top2_next  = top3;
                    depth_next = depth_reg - DEPTH_W'(1);
                end
                OP_SWAP:
                begin
                    top0_next = top1_reg;
                    top1_next = top0_reg;
                end
                OP_ROT:
                begin
                    top0_next = top2_reg;
                    top1_next = top0_reg;
                    top2_next = top1_reg;
                end
                default:
                begin
                    depth_next = depth_reg;
                end
            endcase
        end
    end

    // Result of the current request.
    always_comb
    begin
        result.status       = ST_OK;
        result.has_output   = 1'b0;
        result.output_kind  = KIND_NUM;
        result.output_value = '0;
        if (under)
        begin
            result.status = ST_UNDER;
        end
        else if (over)
        begin
            result.status = ST_OVER;
        end
        else if (known)
        begin
            case (req.op)
                OP_PRINT:
                begin
                    result.has_output   = 1'b1;
                    result.output_value = top0_reg;
                end
                OP_EMIT:
                begin
                    result.has_output   = 1'b1;
                    result.output_kind  = KIND_CHAR;
                    result.output_value = {{(DATA_W-8){1'b0}}, top0_reg[7:0]};
                end
                OP_CR:
                begin
                    result.has_output  = 1'b1;
                    result.output_kind = KIND_NL;
                end
                default:
                begin
                    result.has_output = 1'b0;
                end
            endcase
        end
    end

    // Control state: depth and bypass flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= '0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            depth_reg     <= depth_next;
            byp_valid_reg <= wr_en;
        end
    end

    // Cached entries and the bypass copy of a spilled entry.
    always_ff @(posedge clk)
    begin
        top0_reg     <= top0_next;
        top1_reg     <= top1_next;
        top2_reg     <= top2_next;
        byp_data_reg <= top2_reg;
    end

`ifndef SYNTHESIS
    // The depth never exceeds the stack size.
    assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_W'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    // A successful push places the literal on top.
    assert property (@(posedge clk) disable iff (!rst_n)
        ok && (req.op == OP_PUSH) |=> top0_reg == $past(req.literal))
        else $error("push did not reach top of stack");

    // The bypass is only live right after a spill.
    assert property (@(posedge clk) disable iff (!rst_n)
        byp_valid_reg |-> $past(wr_en))
        else $error("bypass valid without a spill");

    // The depth moves only on a transfer, and by one at most.
    assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg != $past(depth_reg) |-> $past(accept)
            && ((depth_reg == $past(depth_reg) + DEPTH_W'(1))
                || (depth_reg == $past(depth_reg) - DEPTH_W'(1))))
        else $error("unexpected depth change");
`endif

endmodule

`default_nettype wire

FILE: rtl/forth_data_stack_unit.sv
// Forth data stack unit: request/result handshake and result register.
// Depends on fds_pkg, fds_if and fds_stack.
//
// Usage:
//   The req channel carries one stack operation per transfer (req_type) and,
//   for push, a signed 32-bit literal. The rsp channel returns exactly one
//   result per request: status (ok, underflow, overflow) and, for print,
//   emit and cr, the printed number, character or newline.
//   A failed depth check leaves the stack and its depth unchanged.
//   The result register is loaded at the edge of the request transfer and
//   offered on rsp in the next cycle. Throughput is one request per cycle
//   while the receiver takes results; the top three entries sit in registers
//   and the fourth is prefetched from the stack RAM, so none waits on a read.
//   When the receiver stalls, the result register holds its item and req is
//   still taken in the cycle the held result is transferred; otherwise
//   ready stays low until rsp is free.
//   Reset empties the stack (depth zero) and clears the result valid flag;
//   the RAM contents are not cleared and need no clearing pass.
`default_nettype none

module forth_data_stack_unit
    import fds_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    fds_req_if.sink   req,
    fds_rsp_if.source rsp
);

    logic    accept;
    req_t    req_s;
    result_t result;
    result_t res_reg;
    logic    res_valid_reg;

    // Take a request whenever the result register is free or being drained.
    assign req.ready = !res_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign req_s.op      = op_t'(req.req_type);
    assign req_s.literal = req.literal;

    fds_stack u_stack (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .req    (req_s),
        .result (result)
    );

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= result;
        end
    end

    assign rsp.valid        = res_valid_reg;
    assign rsp.status       = res_reg.status;
    assign rsp.has_output   = res_reg.has_output;
    assign rsp.output_kind  = res_reg.output_kind;
    assign rsp.output_value = res_reg.output_value;

endmodule

`default_nettype wire

FILE: bench/fds_stack_checker.sv
// Scoreboard for the Forth data stack unit: mirrors the stack, predicts each result
// and compares it with what leaves the rsp channel. Depends on fds_pkg and fds_if.
`timescale 1ns / 1ps

module fds_stack_checker
    import fds_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    fds_req_if   req,
    fds_rsp_if   rsp,
    output int   fail_count,
    output int   pending
);

    // Mirror of the stack contents and the number of entries in use.
    logic [DATA_W-1:0] stack_mem [0:STACK_DEPTH-1];
    int                stack_level = 0;

    result_t expected_results[$];
    result_t want;
    result_t got;
    int      mismatches = 0;

    // Runs one operation on the mirror and returns the result it should give.
    function automatic result_t apply_stack_op(input logic [3:0] code,
                                               input logic [DATA_W-1:0] lit);
        result_t           r;
        op_t               op;
        int                need;
        bit                grow;
        logic [DATA_W-1:0] x1;
        logic [DATA_W-1:0] x2;
        logic [DATA_W-1:0] x3;

        r    = '0;
        need = 0;
        grow = 1'b0;
        // Codes past cr are ignored and report ok.
        if (code > OP_CR)
            return r;
        op = op_t'(code);

        case (op)
            OP_PUSH:                     grow = 1'b1;
            OP_DROP, OP_PRINT, OP_EMIT:  need = 1;
            OP_DUP:
            begin
                need = 1;
                grow = 1'b1;
            end
            OP_SWAP:                     need = 2;
            OP_ROT:                      need = 3;
            OP_OVER:
            begin
                need = 2;
                grow = 1'b1;
            end
            default: ;
        endcase

        // Underflow is checked before overflow; a failed check changes nothing.
        if (stack_level < need)
        begin
            r.status = ST_UNDER;
            return r;
        end
        if (grow && stack_level >= STACK_DEPTH)
        begin
            r.status = ST_OVER;
            return r;
        end

        case (op)
            OP_PUSH:
            begin
                stack_mem[stack_level] = lit;
                stack_level++;
            end
            OP_DROP: stack_level--;
            OP_DUP:
            begin
                stack_mem[stack_level] = stack_mem[stack_level-1];
                stack_level++;
            end
            OP_SWAP:
            begin
                x1 = stack_mem[stack_level-2];
                stack_mem[stack_level-2] = stack_mem[stack_level-1];
                stack_mem[stack_level-1] = x1;
            end
            // Standard order: x1 x2 x3 becomes x2 x3 x1.
            OP_ROT:
            begin
                x1 = stack_mem[stack_level-3];
                x2 = stack_mem[stack_level-2];
                x3 = stack_mem[stack_level-1];
                stack_mem[stack_level-3] = x2;
                stack_mem[stack_level-2] = x3;
                stack_mem[stack_level-1] = x1;
            end
            OP_OVER:
            begin
                stack_mem[stack_level] = stack_mem[stack_level-2];
                stack_level++;
            end
            OP_PRINT:
            begin
                stack_level--;
                r.has_output   = 1'b1;
                r.output_kind  = KIND_NUM;
                r.output_value = stack_mem[stack_level];
            end
            OP_EMIT:
            begin
                stack_level--;
                r.has_output   = 1'b1;
                r.output_kind  = KIND_CHAR;
                r.output_value = {{(DATA_W-8){1'b0}}, stack_mem[stack_level][7:0]};
            end
            default:
            begin
                r.has_output  = 1'b1;
                r.output_kind = KIND_NL;
            end
        endcase
        return r;
    endfunction

    // Counts a failure and prints the first ten of them.
    task automatic note_failure(input string what, input result_t want_r,
                                input result_t got_r);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected st=%0d out=%0d kind=%0d val=%h, got st=%0d out=%0d kind=%0d val=%h",
                     $realtime, what, want_r.status, want_r.has_output, want_r.output_kind,
                     want_r.output_value, got_r.status, got_r.has_output, got_r.output_kind,
                     got_r.output_value);
    endtask

    // Predict on every request transfer, compare on every result transfer.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
                expected_results.push_back(apply_stack_op(req.req_type, req.literal));

            if (rsp.valid && rsp.ready)
            begin
                got.status       = status_t'(rsp.status);
                got.has_output   = rsp.has_output;
                got.output_kind  = kind_t'(rsp.output_kind);
                got.output_value = rsp.output_value;
                if (expected_results.size() == 0)
                begin
                    note_failure("result with none pending", '0, got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status || got.has_output !== want.has_output ||
                        got.output_kind !== want.output_kind ||
                        got.output_value !== want.output_value)
                        note_failure("wrong result", want, got);
                end
            end

            pending    <= expected_results.size();
            fail_count <= mismatches;
        end
    end

endmodule

FILE: bench/forth_data_stack_unit_tb.sv
// Top of the Forth data stack unit bench: clock, reset, request stimulus, result stalls
// and the verdict. Depends on fds_pkg, fds_if, the block and fds_stack_checker.
`timescale 1ns / 1ps

module forth_data_stack_unit_tb
    import fds_pkg::*;
;

    // Request codes beyond cr, which the block ignores.
    localparam logic [3:0] OP_UNKNOWN_LO = 4'd9;
    localparam logic [3:0] OP_UNKNOWN_HI = 4'd15;
    localparam int         RANDOM_ITEMS  = 600;
    localparam int         IDLE_LIMIT    = 2000;

    // Shapes of the random stimulus.
    typedef enum int {
        PH_MIX,
        PH_FILL,
        PH_AT_FULL,
        PH_DRAIN,
        PH_AT_EMPTY
    } phase_t;

    logic clk;
    logic rst_n;
    logic no_idle = 1'b0;
    int   stall_left = 0;
    int   rsp_gap = 0;
    int   idle_cycles = 0;
    int   level_est = 0;
    int   sent_count = 0;
    int   fail_count;
    int   pending;

    fds_req_if req_ch ();
    fds_rsp_if rsp_ch ();

    forth_data_stack_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    fds_stack_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Idle length: mostly none or short, now and then long, none in a burst.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Rough depth tracking, used only to steer the stimulus.
    function automatic int level_after(input logic [3:0] code, input int lvl);
        case (code)
            OP_PUSH:                    return (lvl < STACK_DEPTH) ? lvl + 1 : lvl;
            OP_DROP, OP_PRINT, OP_EMIT: return (lvl >= 1) ? lvl - 1 : lvl;
            OP_DUP:   return (lvl >= 1 && lvl < STACK_DEPTH) ? lvl + 1 : lvl;
            OP_OVER:  return (lvl >= 2 && lvl < STACK_DEPTH) ? lvl + 1 : lvl;
            default:  return lvl;
        endcase
    endfunction

    // One request transfer, after an optional gap.
    task automatic send_op(input logic [3:0] code, input logic [DATA_W-1:0] lit);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= code;
        req_ch.literal  <= lit;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        level_est = level_after(code, level_est);
        sent_count++;
        if ($urandom_range(0, 99) < 4)
            no_idle <= !no_idle;
    endtask

    // A random request whose operation mix depends on the phase.
    task automatic send_random(input phase_t phase);
        int                r;
        int                v;
        logic [3:0]        code;
        logic [DATA_W-1:0] lit;
        r = $urandom_range(0, 99);
        if (r < 3)
            code = 4'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI));
        else
        begin
            case (phase)
                PH_FILL:
                    code = (r < 90) ? OP_PUSH : 4'($urandom_range(OP_DROP, OP_CR));
                PH_DRAIN:
                    if (r < 90)
                        case (r % 3)
                            0:       code = OP_DROP;
                            1:       code = OP_PRINT;
                            default: code = OP_EMIT;
                        endcase
                    else
                        code = 4'($urandom_range(OP_PUSH, OP_CR));
                // At the top only growing and neutral operations, to hit overflow.
                PH_AT_FULL:
                    case (r % 6)
                        0:       code = OP_PUSH;
                        1:       code = OP_DUP;
                        2:       code = OP_OVER;
                        3:       code = OP_SWAP;
                        4:       code = OP_ROT;
                        default: code = OP_CR;
                    endcase
                PH_AT_EMPTY:
                    code = 4'($urandom_range(OP_DROP, OP_CR));
                default:
                    code = 4'($urandom_range(OP_PUSH, OP_CR));
            endcase
        end
        v = $urandom_range(0, 19);
        case (v)
            0:       lit = 32'h7FFF_FFFF;
            1:       lit = 32'h8000_0000;
            2:       lit = 32'h0000_0000;
            3:       lit = 32'hFFFF_FFFF;
            default: lit = $urandom;
        endcase
        send_op(code, lit);
    endtask

    // Result side: random stalls of the receiver, held low during reset.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else
        begin
            rsp_gap       = idle_len();
            rsp_ch.ready <= (rsp_gap == 0);
            stall_left   <= (rsp_gap > 0) ? rsp_gap - 1 : 0;
        end
    end

    // Watchdog: ends the run after too long without any transfer.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("forth_data_stack_unit: mismatch");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= OP_PUSH;
        req_ch.literal  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every operation but push and cr on an empty stack, then cr and ignored codes.
        send_op(OP_DROP, 32'hFFFF_FFFF);
        send_op(OP_DUP, 32'hFFFF_FFFF);
        send_op(OP_SWAP, 32'hFFFF_FFFF);
        send_op(OP_ROT, 32'hFFFF_FFFF);
        send_op(OP_OVER, 32'hFFFF_FFFF);
        send_op(OP_PRINT, 32'hFFFF_FFFF);
        send_op(OP_EMIT, 32'hFFFF_FFFF);
        send_op(OP_CR, 32'hFFFF_FFFF);
        send_op(OP_UNKNOWN_LO, 32'h1234_5678);
        send_op(OP_UNKNOWN_HI, 32'h8765_4321);
        // Swap and rot one entry short, then the rearranging words on real data.
        send_op(OP_PUSH, 32'h7FFF_FFFF);
        send_op(OP_SWAP, '0);
        send_op(OP_PUSH, 32'h8000_0000);
        send_op(OP_ROT, '0);
        send_op(OP_PUSH, 32'hFFFF_FFFF);
        send_op(OP_PUSH, 32'h1234_5680);
        send_op(OP_ROT, '0);
        send_op(OP_OVER, '0);
        send_op(OP_SWAP, '0);
        send_op(OP_DUP, '0);
        send_op(OP_EMIT, '0);
        send_op(OP_PRINT, '0);
        send_op(OP_DROP, '0);
        send_op(OP_PRINT, '0);
        send_op(OP_EMIT, '0);

        // Random part: mixed traffic, a climb to overflow, a drain to underflow.
        repeat (20) send_random(PH_MIX);
        while (level_est < STACK_DEPTH)
            send_random(PH_FILL);
        repeat (15) send_random(PH_AT_FULL);
        while (level_est > 0)
            send_random(PH_DRAIN);
        repeat (10) send_random(PH_AT_EMPTY);
        while (sent_count < RANDOM_ITEMS + 25)
            send_random(PH_MIX);
        req_ch.valid <= 1'b0;

        // Drain the outstanding results, then allow a few cycles for strays.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("forth_data_stack_unit: match");
        else
            $display("forth_data_stack_unit: mismatch");
        $finish;
    end

endmodule

FILE: forth_data_stack_unit.f
rtl/fds_pkg.sv
rtl/fds_if.sv
rtl/fds_ram.sv
rtl/fds_stack.sv
rtl/forth_data_stack_unit.sv
bench/fds_stack_checker.sv
bench/forth_data_stack_unit_tb.sv
